[rtl/core/svslw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svslw_pkg: shared types and constants of the servo pulse slew limiter
// Register map, register reset values, serial divider sizes and the
// constants of the slew step rounding.
// ----------------------------------------------------------------------------
package svslw_pkg;

   // register file
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_ANGLE_MIN  = 3'd0;
   localparam logic [2:0] REG_ANGLE_MAX  = 3'd1;
   localparam logic [2:0] REG_PULSE_MIN  = 3'd2;
   localparam logic [2:0] REG_PULSE_NEU  = 3'd3;
   localparam logic [2:0] REG_PULSE_MAX  = 3'd4;
   localparam logic [2:0] REG_PULSE_SAFE = 3'd5;
   localparam logic [2:0] REG_SLEW_RATE  = 3'd6;

   localparam logic signed [15:0] ANGLE_MIN_RST  = -16'sd5000;
   localparam logic [14:0]        ANGLE_MAX_RST  = 15'd5000;
   localparam logic [11:0]        PULSE_MIN_RST  = 12'd1350;
   localparam logic [11:0]        PULSE_NEU_RST  = 12'd1500;
   localparam logic [11:0]        PULSE_MAX_RST  = 12'd1650;
   localparam logic [11:0]        PULSE_SAFE_RST = 12'd1500;
   localparam logic [15:0]        SLEW_RATE_RST  = 16'd1200;

   localparam logic [11:0]        PULSE_RESET    = 12'd1500;

   typedef struct packed {
      logic signed [15:0] angle_min;
      logic [14:0]        angle_max;
      logic [11:0]        pulse_min;
      logic [11:0]        pulse_neu;
      logic [11:0]        pulse_max;
      logic [11:0]        pulse_safe;
      logic [15:0]        slew_rate;
   } cfg_type;

   // serial divider: a quotient of 2**DIV_QUO_W or more only flags saturation
   localparam int DIV_NUM_W = 50;
   localparam int DIV_DEN_W = 21;
   localparam int DIV_QUO_W = 13;
   localparam int DIV_REM_W = DIV_DEN_W + DIV_QUO_W;
   localparam int DIV_CNT_W = 4;

   typedef struct packed {
      logic                 done;
      logic                 sat;
      logic [DIV_QUO_W-1:0] quo;
      logic [DIV_DEN_W-1:0] rem;
   } div_res_type;

   // step = (2*rate*elapsed + SLEW_BIAS) / SLEW_DEN; an upward step rounds up
   // one more when the remainder is SLEW_LAST
   localparam logic [DIV_NUM_W-1:0] SLEW_BIAS = 50'd999999;
   localparam logic [DIV_DEN_W-1:0] SLEW_DEN  = 21'd2000000;
   localparam logic [DIV_DEN_W-1:0] SLEW_LAST = 21'd1999999;

endpackage
`default_nettype wire

[rtl/core/svslw_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svslw_csr: configuration register file
// APB-style write and read of the mapping limits, pulses and slew rate.
// ----------------------------------------------------------------------------
module svslw_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [svslw_pkg::ADDR_W-1:0] paddr,
   input  wire logic [svslw_pkg::DATA_W-1:0] pwdata,
   output      logic [svslw_pkg::DATA_W-1:0] prdata,
   output      logic                         pready,
   output      svslw_pkg::cfg_type           cfg
);
   import svslw_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr_en;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_ANGLE_MIN:  cfg_in.angle_min  = pwdata[15:0];
            REG_ANGLE_MAX:  cfg_in.angle_max  = pwdata[14:0];
            REG_PULSE_MIN:  cfg_in.pulse_min  = pwdata[11:0];
            REG_PULSE_NEU:  cfg_in.pulse_neu  = pwdata[11:0];
            REG_PULSE_MAX:  cfg_in.pulse_max  = pwdata[11:0];
            REG_PULSE_SAFE: cfg_in.pulse_safe = pwdata[11:0];
            REG_SLEW_RATE:  cfg_in.slew_rate  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ANGLE_MIN:  prdata = 32'(cfg_ff.angle_min);
         REG_ANGLE_MAX:  prdata = 32'(cfg_ff.angle_max);
         REG_PULSE_MIN:  prdata = 32'(cfg_ff.pulse_min);
         REG_PULSE_NEU:  prdata = 32'(cfg_ff.pulse_neu);
         REG_PULSE_MAX:  prdata = 32'(cfg_ff.pulse_max);
         REG_PULSE_SAFE: prdata = 32'(cfg_ff.pulse_safe);
         REG_SLEW_RATE:  prdata = 32'(cfg_ff.slew_rate);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_min  <= ANGLE_MIN_RST;
         cfg_ff.angle_max  <= ANGLE_MAX_RST;
         cfg_ff.pulse_min  <= PULSE_MIN_RST;
         cfg_ff.pulse_neu  <= PULSE_NEU_RST;
         cfg_ff.pulse_max  <= PULSE_MAX_RST;
         cfg_ff.pulse_safe <= PULSE_SAFE_RST;
         cfg_ff.slew_rate  <= SLEW_RATE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/svslw_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svslw_div: bit-serial restoring divider
// One quotient bit per cycle, most significant first. A numerator at or
// above the divisor shifted by the quotient width only flags saturation.
// ----------------------------------------------------------------------------
module svslw_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [svslw_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [svslw_pkg::DIV_DEN_W-1:0] den,
   output      svslw_pkg::div_res_type          res
);
   import svslw_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 sat_ff, sat_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_REM_W-1:0] dsh_ff, dsh_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic                 sat_c;
   logic                 ge;
   logic [DIV_REM_W-1:0] diff;

   assign sat_c = num >= {{(DIV_NUM_W-DIV_REM_W){1'b0}}, den, {DIV_QUO_W{1'b0}}};
   assign ge    = rem_ff >= dsh_ff;
   assign diff  = rem_ff - dsh_ff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = ~sat_c;
         done_in = sat_c;
         sat_in  = sat_c;
         cnt_in  = DIV_CNT_W'(DIV_QUO_W - 1);
         rem_in  = num[DIV_REM_W-1:0];
         dsh_in  = {1'b0, den, {(DIV_QUO_W-1){1'b0}}};
         quo_in  = '0;
      end else if (run_ff) begin
         // shift in one quotient bit, subtract where it fits
         rem_in = ge ? diff : rem_ff;
         quo_in = {quo_ff[DIV_QUO_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign res.done = done_ff;
   assign res.sat  = sat_ff;
   assign res.quo  = quo_ff;
   assign res.rem  = rem_ff[DIV_DEN_W-1:0];

endmodule
`default_nettype wire

[rtl/core/servo_angle_to_pulse_slew_limiter.sv]
`default_nettype none
// One item at a time: the next item is accepted in the cycle after the
// result register loads. One bit-serial divider is shared by the mapping
// division and the slew division of a command. Synchronous active-high
// reset restores the defaults.
// ----------------------------------------------------------------------------
// servo_angle_to_pulse_slew_limiter: servo angle to pulse width mapper
// Clips the angle, maps it piecewise-linearly to a pulse, clips to the hard
// limits and limits the pulse change per elapsed time, or outputs the safe pulse.
// ----------------------------------------------------------------------------
module servo_angle_to_pulse_slew_limiter #(
   parameter int HARD_MIN_US = 1100,
   parameter int HARD_MAX_US = 1900
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_op,
   input  wire logic signed [15:0]           req_angle_mdeg,
   input  wire logic [31:0]                  req_now_us,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [11:0]                  rsp_pulse_width_us,
   output      logic signed [15:0]           rsp_held_angle_mdeg,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [svslw_pkg::ADDR_W-1:0] paddr,
   input  wire logic [svslw_pkg::DATA_W-1:0] pwdata,
   output      logic [svslw_pkg::DATA_W-1:0] prdata,
   output      logic                         pready
);
   import svslw_pkg::*;

   localparam logic [11:0] HARD_MIN = 12'(HARD_MIN_US);
   localparam logic [11:0] HARD_MAX = 12'(HARD_MAX_US);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_NUM  = 3'd2;
   localparam logic [2:0] S_MDIV = 3'd3;
   localparam logic [2:0] S_SNUM = 3'd4;
   localparam logic [2:0] S_SDIV = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   function automatic logic [11:0] clip_hard(input logic [14:0] v);
      logic [11:0] r;
      if (v < 15'(HARD_MIN)) begin
         r = HARD_MIN;
      end else if (v > 15'(HARD_MAX)) begin
         r = HARD_MAX;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

   cfg_type     cfg;
   div_res_type div_res;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;

   logic [2:0]         state_ff, state_in;
   logic               op_ff, op_in;
   logic signed [15:0] ang_ff, ang_in;
   logic [31:0]        now_ff, now_in;
   logic [31:0]        elap_ff, elap_in;
   logic               direct_ff, direct_in;
   logic               zero_ff, zero_in;
   logic [27:0]        p_neu_ff, p_neu_in;
   logic signed [29:0] p_ang_ff, p_ang_in;
   logic [15:0]        lim_ff, lim_in;
   logic [47:0]        re_ff, re_in;
   logic [11:0]        tgt_ff, tgt_in;
   logic [11:0]        nx_ff, nx_in;
   logic [11:0]        pulse_ff, pulse_in;
   logic signed [15:0] held_ff, held_in;
   logic [31:0]        last_ff, last_in;
   logic               known_ff, known_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic signed [15:0] amax_s;
   logic signed [15:0] ang_clip;
   logic [31:0]        elap_c;
   logic               neg;
   logic [16:0]        ang_x;
   logic [15:0]        mag_c;
   logic [15:0]        lim_c;
   logic [11:0]        end_c;
   logic signed [12:0] diff_c;
   logic [33:0]        nsum_c;
   logic [33:0]        m_c;
   logic [DIV_NUM_W-1:0] slew_num;
   logic [13:0]        step_up;
   logic [13:0]        step_dn;
   logic [14:0]        up_c;
   logic signed [15:0] down_c;
   logic [14:0]        nxt_c;

   svslw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   svslw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .res   (div_res)
   );

   assign req_ready           = (state_ff == S_IDLE);
   assign accept              = req_valid & req_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pulse_width_us  = pulse_ff;
   assign rsp_held_angle_mdeg = held_ff;

   // input clip: raise to the minimum first, else lower to the maximum
   assign amax_s = $signed({1'b0, cfg.angle_max});
   always_comb begin
      if (req_angle_mdeg < cfg.angle_min) begin
         ang_clip = cfg.angle_min;
      end else if (req_angle_mdeg > amax_s) begin
         ang_clip = amax_s;
      end else begin
         ang_clip = req_angle_mdeg;
      end
   end
   assign elap_c = req_now_us - last_ff;

   // mapping operands for the side of zero the angle lies on
   assign neg    = ang_ff[15];
   assign ang_x  = {ang_ff[15], ang_ff};
   assign mag_c  = neg ? 16'(17'd0 - ang_x) : ang_ff;
   assign lim_c  = neg ? 16'(17'd0 - {cfg.angle_min[15], cfg.angle_min})
                       : {1'b0, cfg.angle_max};
   assign end_c  = neg ? cfg.pulse_min : cfg.pulse_max;
   assign diff_c = $signed({1'b0, end_c}) - $signed({1'b0, cfg.pulse_neu});

   // numerator 2*(neutral*lim + mag*diff) + lim, rounded division by 2*lim
   assign nsum_c = {6'b0, p_neu_ff} + {{4{p_ang_ff[29]}}, p_ang_ff};
   assign m_c    = {nsum_c[32:0], 1'b0} + {18'b0, lim_ff};

   assign slew_num = {1'b0, re_ff, 1'b0} + SLEW_BIAS;
   assign div_num  = (state_ff == S_NUM) ? {16'b0, m_c} : slew_num;
   assign div_den  = (state_ff == S_NUM) ? {4'b0, lim_ff, 1'b0} : SLEW_DEN;
   assign div_start = ((state_ff == S_NUM) && !zero_ff && !m_c[33]) ||
                      ((state_ff == S_SNUM) && !direct_ff);

   // slew steps: upward rounds half up, downward rounds half down
   assign step_up = div_res.sat ? '1
                    : 14'(div_res.quo) + 14'(div_res.rem == SLEW_LAST);
   assign step_dn = div_res.sat ? '1 : 14'(div_res.quo);
   assign up_c    = 15'(pulse_ff) + 15'(step_up);
   assign down_c  = $signed({4'b0, pulse_ff}) - $signed({2'b0, step_dn});

   always_comb begin
      if (tgt_ff > pulse_ff) begin
         nxt_c = (15'(tgt_ff) < up_c) ? 15'(tgt_ff) : up_c;
      end else if (tgt_ff < pulse_ff) begin
         nxt_c = ($signed({4'b0, tgt_ff}) > down_c) ? 15'(tgt_ff) : down_c[14:0];
      end else begin
         nxt_c = 15'(tgt_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ang_in       = ang_ff;
      now_in       = now_ff;
      elap_in      = elap_ff;
      direct_in    = direct_ff;
      zero_in      = zero_ff;
      p_neu_in     = p_neu_ff;
      p_ang_in     = p_ang_ff;
      lim_in       = lim_ff;
      re_in        = re_ff;
      tgt_in       = tgt_ff;
      nx_in        = nx_ff;
      pulse_in     = pulse_ff;
      held_in      = held_ff;
      last_in      = last_ff;
      known_in     = known_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               ang_in    = ang_clip;
               now_in    = req_now_us;
               elap_in   = elap_c;
               direct_in = !known_ff || (cfg.slew_rate == '0) || (elap_c == '0);
               nx_in     = cfg.pulse_safe;
               state_in  = req_op ? S_DONE : S_MUL;
            end
         end
         S_MUL: begin
            zero_in  = (ang_ff == '0);
            lim_in   = lim_c;
            p_neu_in = 28'(cfg.pulse_neu) * 28'(lim_c);
            p_ang_in = 30'($signed({1'b0, mag_c})) * 30'(diff_c);
            re_in    = 48'(cfg.slew_rate) * 48'(elap_ff);
            state_in = S_NUM;
         end
         S_NUM: begin
            if (zero_ff) begin
               tgt_in   = clip_hard(15'(cfg.pulse_neu));
               state_in = S_SNUM;
            end else if (m_c[33]) begin
               tgt_in   = HARD_MIN;
               state_in = S_SNUM;
            end else begin
               state_in = S_MDIV;
            end
         end
         S_MDIV: begin
            if (div_res.done) begin
               tgt_in   = div_res.sat ? HARD_MAX : clip_hard(15'(div_res.quo));
               state_in = S_SNUM;
            end
         end
         S_SNUM: begin
            if (direct_ff) begin
               nx_in    = tgt_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            if (div_res.done) begin
               nx_in    = clip_hard(nxt_c);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // load the result register once the previous item has left
            if (!rsp_valid_ff || rsp_ready) begin
               pulse_in     = nx_ff;
               held_in      = op_ff ? '0 : ang_ff;
               last_in      = now_ff;
               known_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pulse_ff     <= PULSE_RESET;
         held_ff      <= '0;
         last_ff      <= '0;
         known_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pulse_ff     <= pulse_in;
         held_ff      <= held_in;
         last_ff      <= last_in;
         known_ff     <= known_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      ang_ff    <= ang_in;
      now_ff    <= now_in;
      elap_ff   <= elap_in;
      direct_ff <= direct_in;
      zero_ff   <= zero_in;
      p_neu_ff  <= p_neu_in;
      p_ang_ff  <= p_ang_in;
      lim_ff    <= lim_in;
      re_ff     <= re_in;
      tgt_ff    <= tgt_in;
      nx_ff     <= nx_in;
   end

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == S_MDIV || state_ff == S_SDIV))
      else $error("divider finished outside a division wait state");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not leave idle");

   a_pulse_hard: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !op_ff && HARD_MIN <= HARD_MAX)
         |-> (nx_ff >= HARD_MIN && nx_ff <= HARD_MAX))
      else $error("angle command pulse outside hard limits");

   a_known_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> known_ff)
      else $error("result delivered without a time stamp recorded");

endmodule
`default_nettype wire

[test/servo_angle_to_pulse_slew_limiter_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// servo_angle_to_pulse_slew_limiter_test: self-checking bench of the slew limiter
// A short table of directed commands and register writes runs first; then
// phases of random commands, each under its own register set and a traffic
// pattern. Every result is compared against its table row's expected values
// or an in-bench prediction of the angle clip, pulse mapping and slew step.
// ----------------------------------------------------------------------------
module servo_angle_to_pulse_slew_limiter_test;
   import svslw_pkg::*;

   localparam int HARD_MIN_US   = 1100;
   localparam int HARD_MAX_US   = 1900;
   localparam int SETTLE_CYCLES = 40;
   localparam int STUCK_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 200;
   localparam int REG_COUNT     = 7;

   typedef enum logic {
      OP_ANGLE = 1'b0,
      OP_SAFE  = 1'b1
   } servo_op_t;

   typedef struct packed {
      logic [11:0]        pulse;
      logic signed [15:0] held;
   } servo_result_t;

   typedef struct packed {
      bit                 is_reg;
      logic [2:0]         idx;
      logic [31:0]        value;
      servo_op_t          op;
      logic signed [15:0] ang;
      logic [31:0]        now;
      bit                 typed;
      logic [11:0]        exp_pulse;
      logic signed [15:0] exp_held;
   } servo_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = 1'b0;
   logic signed [15:0]  req_angle_mdeg = '0;
   logic [31:0]         req_now_us = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [11:0]         rsp_pulse_width_us;
   logic signed [15:0]  rsp_held_angle_mdeg;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // register mirror
   longint m_angle_min = ANGLE_MIN_RST;
   longint m_angle_max = ANGLE_MAX_RST;
   longint m_pulse_min = PULSE_MIN_RST;
   longint m_pulse_neu = PULSE_NEU_RST;
   longint m_pulse_max = PULSE_MAX_RST;
   longint m_pulse_safe = PULSE_SAFE_RST;
   longint m_rate = SLEW_RATE_RST;
   // servo state mirror
   longint      m_pulse = PULSE_RESET;
   longint      m_held = 0;
   logic [31:0] m_last = '0;
   bit          m_time_known = 1'b0;

   servo_result_t pulse_expected[$];
   servo_row_t    dir_rows[$];
   logic [31:0]   now_track = '0;
   int            mismatch_count = 0;
   int            result_index = 0;
   int            stuck_cycles = 0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            hold_req_cnt = 0;
   int            hold_ack_cnt = 0;
   int            hold_left = 0;

   servo_angle_to_pulse_slew_limiter #(
      .HARD_MIN_US(HARD_MIN_US),
      .HARD_MAX_US(HARD_MAX_US)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_angle_mdeg(req_angle_mdeg),
      .req_now_us(req_now_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pulse_width_us(rsp_pulse_width_us),
      .rsp_held_angle_mdeg(rsp_held_angle_mdeg),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic longint floor_quot(input longint x, input longint y);
      if (x >= 0) return x / y;
      return -((-x + y - 1) / y);
   endfunction

   function automatic longint round_half_up(input longint n, input longint d);
      return floor_quot(2 * n + d, 2 * d);
   endfunction

   function automatic longint hard_clip(input longint p);
      if (p < HARD_MIN_US) return HARD_MIN_US;
      if (p > HARD_MAX_US) return HARD_MAX_US;
      return p;
   endfunction

   function automatic void cfg_store(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_ANGLE_MIN:  m_angle_min = longint'($signed(value[15:0]));
         REG_ANGLE_MAX:  m_angle_max = longint'(value[14:0]);
         REG_PULSE_MIN:  m_pulse_min = longint'(value[11:0]);
         REG_PULSE_NEU:  m_pulse_neu = longint'(value[11:0]);
         REG_PULSE_MAX:  m_pulse_max = longint'(value[11:0]);
         REG_PULSE_SAFE: m_pulse_safe = longint'(value[11:0]);
         REG_SLEW_RATE:  m_rate = longint'(value[15:0]);
         default: ;
      endcase
   endfunction

   // advance the servo state by one item and return the pulse and angle it shows
   function automatic servo_result_t servo_predict(input servo_op_t op,
         input logic signed [15:0] ang, input logic [31:0] now);
      servo_result_t res;
      longint a, lim, span_end, target, re, nxt, c;
      logic [31:0] elapsed;
      if (op == OP_SAFE) begin
         m_held = 0;
         m_pulse = m_pulse_safe;
      end else begin
         a = ang;
         if (a < m_angle_min) a = m_angle_min;
         else if (a > m_angle_max) a = m_angle_max;
         m_held = a;
         if (a == 0) begin
            target = hard_clip(m_pulse_neu);
         end else begin
            if (a > 0) begin
               lim = m_angle_max;
               span_end = m_pulse_max;
            end else begin
               lim = -m_angle_min;
               span_end = m_pulse_min;
               a = -a;
            end
            target = hard_clip(round_half_up(m_pulse_neu * lim + a * (span_end - m_pulse_neu),
                                             lim));
         end
         elapsed = now - m_last;
         if (!m_time_known || m_rate == 0 || elapsed == 0) begin
            m_pulse = target;
         end else begin
            re = m_rate * longint'(elapsed);
            if (target > m_pulse) begin
               nxt = m_pulse + round_half_up(re, 1000000);
               if (target < nxt) nxt = target;
            end else if (target < m_pulse) begin
               // a downward step rounds half down, so it loses the half
               c = 2 * re - 1000000;
               c = (c <= 0) ? 0 : (c + 1999999) / 2000000;
               nxt = m_pulse - c;
               if (target > nxt) nxt = target;
            end else begin
               nxt = target;
            end
            m_pulse = hard_clip(nxt);
         end
      end
      m_last = now;
      m_time_known = 1'b1;
      res.pulse = m_pulse[11:0];
      res.held = m_held[15:0];
      return res;
   endfunction

   function automatic servo_row_t cmd_row(input servo_op_t op, input logic signed [15:0] ang,
         input logic [31:0] now);
      servo_row_t r;
      r = '0;
      r.op = op;
      r.ang = ang;
      r.now = now;
      return r;
   endfunction

   function automatic servo_row_t chk_row(input servo_op_t op, input logic signed [15:0] ang,
         input logic [31:0] now, input logic [11:0] pulse, input logic signed [15:0] held);
      servo_row_t r;
      r = cmd_row(op, ang, now);
      r.typed = 1'b1;
      r.exp_pulse = pulse;
      r.exp_held = held;
      return r;
   endfunction

   function automatic servo_row_t reg_row(input logic [2:0] idx, input logic [31:0] value);
      servo_row_t r;
      r = '0;
      r.is_reg = 1'b1;
      r.idx = idx;
      r.value = value;
      return r;
   endfunction

   function automatic logic [31:0] random_reg_value(input logic [2:0] idx);
      logic [31:0] v;
      // full words also exercise the ignored upper bits
      if ($urandom_range(3) == 0) return $urandom();
      case (idx)
         REG_ANGLE_MIN: v = -$urandom_range(1, 32768);
         REG_ANGLE_MAX: v = $urandom_range(1, 32767);
         REG_SLEW_RATE: begin
            case ($urandom_range(3))
               0: v = 0;
               1: v = $urandom_range(1, 5000);
               2: v = 65535;
               default: v = $urandom_range(0, 65535);
            endcase
         end
         default: v = $urandom_range(1000, 2000);
      endcase
      return v;
   endfunction

   function automatic servo_row_t random_row();
      servo_row_t r;
      int unsigned pick;
      r = '0;
      r.op = ($urandom_range(99) < 8) ? OP_SAFE : OP_ANGLE;
      pick = $urandom_range(99);
      if (pick < 15 || m_angle_min > m_angle_max) begin
         r.ang = $urandom();
      end else if (pick < 30) begin
         case ($urandom_range(5))
            0: r.ang = 16'sh8000;
            1: r.ang = 16'sh7FFF;
            2: r.ang = 16'(m_angle_min);
            3: r.ang = 16'(m_angle_max);
            4: r.ang = 16'sh0000;
            default: r.ang = -16'sd1;
         endcase
      end else begin
         r.ang = 16'(m_angle_min +
                     longint'($urandom_range(32'(m_angle_max - m_angle_min))));
      end
      // small steps keep the slew in play; one pick in ten repeats the last timestamp
      pick = $urandom_range(99);
      if (pick < 45) now_track += $urandom_range(1, 3000);
      else if (pick < 70) now_track += $urandom_range(3001, 1000000);
      else if (pick < 80) now_track += $urandom_range(1000001, 50000000);
      else if (pick < 85) now_track = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      else if (pick < 90) now_track = $urandom();
      r.now = now_track;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      cfg_store(idx, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic offer_item(input servo_row_t r);
      servo_result_t want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = r.op;
      req_angle_mdeg = r.ang;
      req_now_us = r.now;
      do @(posedge clock); while (!req_ready);
      want = servo_predict(r.op, r.ang, r.now);
      if (r.typed) begin
         want.pulse = r.exp_pulse;
         want.held = r.exp_held;
      end
      pulse_expected.push_back(want);
      @(negedge clock);
   endtask

   task automatic wait_results(input int settle);
      req_valid = 1'b0;
      while (pulse_expected.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // receiver: random stalls, plus a long hold on request
   always @(negedge clock) begin
      if (hold_req_cnt != hold_ack_cnt) begin
         hold_ack_cnt = hold_req_cnt;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      servo_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_index++;
         if (pulse_expected.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", result_index));
         end else begin
            want = pulse_expected.pop_front();
            if (rsp_pulse_width_us !== want.pulse)
               report_mismatch($sformatf("result %0d pulse_width_us %0d, expected %0d",
                                         result_index, rsp_pulse_width_us, want.pulse));
            if (rsp_held_angle_mdeg !== want.held)
               report_mismatch($sformatf("result %0d held_angle_mdeg %0d, expected %0d",
                                         result_index, rsp_held_angle_mdeg, want.held));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("servo_angle_to_pulse_slew_limiter verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] vals [REG_COUNT];

      // reset defaults first, then half steps, raw pulses, odd angle limits
      dir_rows.push_back(chk_row(OP_ANGLE, 16'sd0, 32'd0, 12'd1500, 16'sd0));
      dir_rows.push_back(chk_row(OP_ANGLE, 16'sh7FFF, 32'd1000000, 12'd1650, 16'sd5000));
      dir_rows.push_back(chk_row(OP_ANGLE, 16'sh8000, 32'd1000000, 12'd1350, -16'sd5000));
      dir_rows.push_back(chk_row(OP_SAFE, 16'sh7FFF, 32'd5, 12'd1500, 16'sd0));
      dir_rows.push_back(chk_row(OP_ANGLE, 16'sd5000, 32'd6, 12'd1500, 16'sd5000));
      dir_rows.push_back(cmd_row(OP_ANGLE, -16'sd5000, 32'hFFFF_FFFF));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sd2500, 32'd3));
      dir_rows.push_back(reg_row(REG_SLEW_RATE, 32'd1000));
      dir_rows.push_back(chk_row(OP_SAFE, -16'sd1, 32'd100, 12'd1500, 16'sd0));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sd5000, 32'd600));
      dir_rows.push_back(cmd_row(OP_ANGLE, -16'sd5000, 32'd1100));
      dir_rows.push_back(reg_row(REG_SLEW_RATE, 32'd0));
      dir_rows.push_back(chk_row(OP_ANGLE, 16'sd5000, 32'd1101, 12'd1650, 16'sd5000));
      dir_rows.push_back(reg_row(REG_PULSE_SAFE, 32'd0));
      dir_rows.push_back(chk_row(OP_SAFE, 16'sd0, 32'd1200, 12'd0, 16'sd0));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sd0, 32'd1300));
      dir_rows.push_back(reg_row(REG_PULSE_SAFE, 32'hFFFF_FFFF));
      dir_rows.push_back(chk_row(OP_SAFE, 16'sd0, 32'd1400, 12'd4095, 16'sd0));
      dir_rows.push_back(reg_row(REG_PULSE_MIN, 32'd0));
      dir_rows.push_back(reg_row(REG_PULSE_NEU, 32'd4095));
      dir_rows.push_back(reg_row(REG_PULSE_MAX, 32'd4095));
      dir_rows.push_back(reg_row(REG_SLEW_RATE, 32'd65535));
      dir_rows.push_back(chk_row(OP_ANGLE, 16'sd0, 32'd1500, 12'd1900, 16'sd0));
      dir_rows.push_back(cmd_row(OP_ANGLE, -16'sd1, 32'd1500));
      // inverted limits: raise to the minimum wins over the maximum
      dir_rows.push_back(reg_row(REG_ANGLE_MIN, 32'h0000_0064));
      dir_rows.push_back(reg_row(REG_ANGLE_MAX, 32'd50));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sd0, 32'd2000));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sh7FFF, 32'd2001));
      // both limits zero through masked upper bits
      dir_rows.push_back(reg_row(REG_ANGLE_MAX, 32'hFFFF_8000));
      dir_rows.push_back(reg_row(REG_ANGLE_MIN, 32'hFFFF_0000));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sd0, 32'd2100));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sh8000, 32'd2200));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sd5, 32'd2300));
      dir_rows.push_back(reg_row(REG_ANGLE_MIN, 32'h0000_8000));
      dir_rows.push_back(reg_row(REG_ANGLE_MAX, 32'd32767));
      dir_rows.push_back(reg_row(REG_PULSE_MIN, 32'd1350));
      dir_rows.push_back(reg_row(REG_PULSE_NEU, 32'd1500));
      dir_rows.push_back(reg_row(REG_PULSE_MAX, 32'd1650));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sh8000, 32'd2400));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sh7FFF, 32'd2401));
      dir_rows.push_back(cmd_row(OP_ANGLE, 16'sh4000, 32'h8000_0000));

      repeat (7) @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 11;
      rsp_stall_pct = 11;
      foreach (dir_rows[k]) begin
         if (dir_rows[k].is_reg) begin
            wait_results(SETTLE_CYCLES);
            csr_write(dir_rows[k].idx, dir_rows[k].value);
         end else begin
            offer_item(dir_rows[k]);
         end
      end
      now_track = 32'h8000_0000;

      for (int p = 0; p < PHASES; p++) begin
         wait_results(SETTLE_CYCLES);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 75; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 75; end
            default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         case (p)
            0: begin
               vals[REG_ANGLE_MIN] = 32'(ANGLE_MIN_RST);
               vals[REG_ANGLE_MAX] = 32'(ANGLE_MAX_RST);
               vals[REG_PULSE_MIN] = 32'(PULSE_MIN_RST);
               vals[REG_PULSE_NEU] = 32'(PULSE_NEU_RST);
               vals[REG_PULSE_MAX] = 32'(PULSE_MAX_RST);
               vals[REG_PULSE_SAFE] = 32'(PULSE_SAFE_RST);
               vals[REG_SLEW_RATE] = 32'(SLEW_RATE_RST);
            end
            1: begin
               vals[REG_ANGLE_MIN] = 32'h0000_8000;
               vals[REG_ANGLE_MAX] = 32'd32767;
               vals[REG_PULSE_MIN] = 32'd0;
               vals[REG_PULSE_NEU] = 32'd2048;
               vals[REG_PULSE_MAX] = 32'd4095;
               vals[REG_PULSE_SAFE] = 32'd0;
               vals[REG_SLEW_RATE] = 32'd65535;
            end
            2: begin
               vals[REG_ANGLE_MIN] = 32'h0000_FFFF;
               vals[REG_ANGLE_MAX] = 32'd1;
               vals[REG_PULSE_MIN] = 32'd4095;
               vals[REG_PULSE_NEU] = 32'd1500;
               vals[REG_PULSE_MAX] = 32'd0;
               vals[REG_PULSE_SAFE] = 32'd4095;
               vals[REG_SLEW_RATE] = 32'd1;
            end
            default: begin
               for (int i = 0; i < REG_COUNT; i++) vals[i] = random_reg_value(3'(i));
            end
         endcase
         for (int i = 0; i < REG_COUNT; i++) csr_write(3'(i), vals[i]);
         // hold the receiver off while the sender keeps offering items
         if (p == 2) hold_req_cnt++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 5 && n % 40 == 39) wait_results(0);
            offer_item(random_row());
         end
      end

      wait_results(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("servo_angle_to_pulse_slew_limiter verification clean");
      end else begin
         $display("servo_angle_to_pulse_slew_limiter verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/svslw_pkg.sv
rtl/core/svslw_csr.sv
rtl/core/svslw_div.sv
rtl/core/servo_angle_to_pulse_slew_limiter.sv
test/servo_angle_to_pulse_slew_limiter_test.sv
